// ===== rtl/core/ifss_pkg.sv =====
// Image format and size sniffer: shared types and constants.
// Request structs for both channels, JPEG walker status, format and status codes.
// No dependencies.
package ifss_pkg;

  localparam int MAX_BYTES_W = 24;
  localparam logic [MAX_BYTES_W-1:0] MAX_BYTES_RESET = 24'd524288;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_PNG  = 2'd1;
  localparam logic [1:0] KIND_GIF  = 2'd2;
  localparam logic [1:0] KIND_JPEG = 2'd3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_TOO_LARGE = 2'd1;
  localparam logic [1:0] STATUS_BAD       = 2'd2;

  localparam logic [7:0] PNG_LEAD  = 8'h89;
  localparam logic [7:0] GIF_LEAD  = 8'h47;
  localparam logic [7:0] JPEG_LEAD = 8'hFF;
  localparam logic [7:0] JPEG_SOI  = 8'hD8;
  localparam logic [7:0] JPEG_EOI  = 8'hD9;
  localparam logic [7:0] JPEG_SOS  = 8'hDA;
  localparam logic [7:0] GIF_VER_7 = 8'h37;
  localparam logic [7:0] GIF_VER_9 = 8'h39;

  localparam int PNG_MIN_BYTES = 24;
  localparam int GIF_MIN_BYTES = 10;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  format_kind;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [23:0] file_bytes;
  } out_item_t;

  typedef struct packed {
    logic       step;
    logic       clear;
    logic [7:0] data_byte;
  } jpeg_ctl_t;

  typedef struct packed {
    logic        found;
    logic [15:0] width;
    logic [15:0] height;
  } jpeg_stat_t;

  function automatic logic [7:0] png_sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h89;
      3'd1:    b = 8'h50;
      3'd2:    b = 8'h4E;
      3'd3:    b = 8'h47;
      3'd4:    b = 8'h0D;
      3'd5:    b = 8'h0A;
      3'd6:    b = 8'h1A;
      default: b = 8'h0A;
    endcase
    return b;
  endfunction

  // "GIF8?a"; the version digit is checked separately
  function automatic logic [7:0] gif_sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h47;
      3'd1:    b = 8'h49;
      3'd2:    b = 8'h46;
      3'd3:    b = 8'h38;
      3'd4:    b = 8'h37;
      default: b = 8'h61;
    endcase
    return b;
  endfunction

  function automatic logic is_sof(input logic [7:0] m);
    return (m[7:4] == 4'hC) && (m != 8'hC4) && (m != 8'hC8) && (m != 8'hCC);
  endfunction

endpackage

// ===== rtl/core/ifss_jpeg_walk.sv =====
// JPEG marker walker: skips segments and captures size from the first SOF.
// Depends on ifss_pkg for the control and status structs.
module ifss_jpeg_walk
  import ifss_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  jpeg_ctl_t  ctl,
  output jpeg_stat_t stat
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_MARK   = 3'd1;
  localparam logic [2:0] PH_LEN_HI = 3'd2;
  localparam logic [2:0] PH_LEN_LO = 3'd3;
  localparam logic [2:0] PH_SOF    = 3'd4;
  localparam logic [2:0] PH_SKIP   = 3'd5;

  localparam logic [1:0] DONE_NONE  = 2'd0;
  localparam logic [1:0] DONE_FOUND = 2'd1;
  localparam logic [1:0] DONE_FAIL  = 2'd2;

  logic [2:0]  phase, phase_next;
  logic [15:0] skip, skip_next;
  logic [7:0]  marker, marker_next;
  logic [15:0] seg_len, seg_len_next;
  logic [15:0] wid, wid_next;
  logic [15:0] hei, hei_next;
  logic [1:0]  done, done_next;

  always_comb begin
    logic [7:0]  b;
    logic [15:0] len;
    logic [15:0] r;
    b            = ctl.data_byte;
    len          = {seg_len[15:8], b};
    r            = skip - 16'd1;
    phase_next   = phase;
    skip_next    = skip;
    marker_next  = marker;
    seg_len_next = seg_len;
    wid_next     = wid;
    hei_next     = hei;
    done_next    = done;
    if (ctl.step && done == DONE_NONE) begin
      unique case (phase)
        PH_MARK: begin
          if (b == JPEG_LEAD) begin
            phase_next = phase;
          end else if (b == JPEG_EOI || b == JPEG_SOS) begin
            done_next = DONE_FAIL;
          end else begin
            marker_next = b;
            phase_next  = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          seg_len_next = {b, 8'h00};
          phase_next   = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          seg_len_next = len;
          if (len < 16'd2) begin
            done_next = DONE_FAIL;
          end else if (is_sof(marker) && len >= 16'd7) begin
            skip_next  = 16'd5;
            wid_next   = '0;
            hei_next   = '0;
            phase_next = PH_SOF;
          end else begin
            skip_next  = len - 16'd2;
            phase_next = (len != 16'd2) ? PH_SKIP : PH_IDLE;
          end
        end
        PH_SOF: begin
          if (skip == '0) begin
            done_next = DONE_FAIL;
          end else begin
            skip_next = r;
            if (r == 16'd3 || r == 16'd2) begin
              hei_next = {hei[7:0], b};
            end else if (r == 16'd1 || r == 16'd0) begin
              wid_next = {wid[7:0], b};
            end
            if (r == '0) begin
              done_next = (wid_next != '0 && hei != '0) ? DONE_FOUND : DONE_FAIL;
            end
          end
        end
        PH_SKIP: begin
          if (skip != '0) begin
            skip_next = r;
          end
          if (skip == '0 || r == '0) begin
            phase_next = PH_IDLE;
          end
        end
        default: begin
          phase_next = (b == JPEG_LEAD) ? PH_MARK : PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      phase   <= PH_IDLE;
      skip    <= '0;
      marker  <= '0;
      seg_len <= '0;
      wid     <= '0;
      hei     <= '0;
      done    <= DONE_NONE;
    end else begin
      phase   <= phase_next;
      skip    <= skip_next;
      marker  <= marker_next;
      seg_len <= seg_len_next;
      wid     <= wid_next;
      hei     <= hei_next;
      done    <= done_next;
    end
  end

  assign stat.found  = (done_next == DONE_FOUND);
  assign stat.width  = wid_next;
  assign stat.height = hei_next;

endmodule

// ===== rtl/core/image_format_size_sniffer_core.sv =====
// Image format and size sniffer, top level.
// Depends on ifss_pkg and ifss_jpeg_walk.
//
// Takes one byte of a file per cycle and, on the byte flagged last, delivers one
// result naming the format (PNG, GIF or JPEG), the pixel size and the byte count,
// or a too-large / bad-header status. One byte is accepted every cycle unless a
// last byte is held; the result passes the input register, then the result
// register. Bytes keep flowing while a result waits; only a last byte is held
// while the previous result is still stalled. max_bytes is written through
// cfg_write/cfg_data; the user must write it only while no file is in flight,
// and the block itself does not enforce this.
module image_format_size_sniffer_core
  import ifss_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [MAX_BYTES_W-1:0] cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_item
);

  localparam int CMP_W = (COUNT_BITS > MAX_BYTES_W) ? COUNT_BITS : MAX_BYTES_W;

  logic [MAX_BYTES_W-1:0] max_bytes;

  logic       in_full;
  logic [7:0] in_byte;
  logic       in_last;

  logic [5:0]            pos, pos_next;
  logic [1:0]            guess, guess_next;
  logic                  match, match_next;
  logic [31:0]           wacc, wacc_next;
  logic [31:0]           hacc, hacc_next;
  logic [COUNT_BITS-1:0] cnt, cnt_next;
  logic                  too_large, too_large_next;

  logic       proc_ok, proc, finish, accept;
  jpeg_ctl_t  jctl;
  jpeg_stat_t jstat;
  out_item_t  res_next;

  assign proc_ok  = !in_last || !out_valid || !out_stall;
  assign proc     = in_full && proc_ok;
  assign finish   = proc && in_last;
  assign in_stall = in_full && !proc_ok;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= MAX_BYTES_RESET;
    end else if (cfg_write) begin
      max_bytes <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (proc) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte <= in_item.data_byte;
      in_last <= in_item.last_byte;
    end
  end

  always_comb begin
    cnt_next       = (cnt != '1) ? cnt + 1'b1 : cnt;
    too_large_next = too_large || (CMP_W'(cnt_next) > CMP_W'(max_bytes));
    pos_next       = (pos != '1) ? pos + 6'd1 : pos;
    guess_next     = guess;
    match_next     = match;
    wacc_next      = wacc;
    hacc_next      = hacc;
    if (pos == 6'd0) begin
      if (in_byte == PNG_LEAD) begin
        guess_next = KIND_PNG;
      end else if (in_byte == GIF_LEAD) begin
        guess_next = KIND_GIF;
      end else if (in_byte == JPEG_LEAD) begin
        guess_next = KIND_JPEG;
      end else begin
        guess_next = KIND_NONE;
      end
      match_next = (guess_next != KIND_NONE);
      wacc_next  = '0;
      hacc_next  = '0;
    end else if (match) begin
      case (guess)
        KIND_PNG: begin
          if (pos < 6'd8) begin
            match_next = (in_byte == png_sig_byte(pos[2:0]));
          end else if (pos >= 6'd16 && pos < 6'd20) begin
            wacc_next = {wacc[23:0], in_byte};
          end else if (pos >= 6'd20 && pos < 6'd24) begin
            hacc_next = {hacc[23:0], in_byte};
          end
        end
        KIND_GIF: begin
          if (pos == 6'd4) begin
            match_next = (in_byte == GIF_VER_7 || in_byte == GIF_VER_9);
          end else if (pos < 6'd6) begin
            match_next = (in_byte == gif_sig_byte(pos[2:0]));
          end else if (pos == 6'd6) begin
            wacc_next[7:0] = wacc[7:0] | in_byte;
          end else if (pos == 6'd7) begin
            wacc_next[15:8] = wacc[15:8] | in_byte;
          end else if (pos == 6'd8) begin
            hacc_next[7:0] = hacc[7:0] | in_byte;
          end else if (pos == 6'd9) begin
            hacc_next[15:8] = hacc[15:8] | in_byte;
          end
        end
        KIND_JPEG: begin
          if (pos == 6'd1) begin
            match_next = (in_byte == JPEG_SOI);
          end
        end
        default: begin
          match_next = match;
        end
      endcase
    end
  end

  assign jctl.step      = proc && match && (guess == KIND_JPEG) && (pos >= 6'd2);
  assign jctl.clear     = finish;
  assign jctl.data_byte = in_byte;

  ifss_jpeg_walk u_jpeg (
    .clk  (clk),
    .rst  (rst),
    .ctl  (jctl),
    .stat (jstat)
  );

  always_comb begin
    res_next              = '0;
    res_next.status       = STATUS_BAD;
    res_next.format_kind  = KIND_NONE;
    res_next.file_bytes   = 24'(cnt_next);
    if (too_large_next) begin
      res_next.status = STATUS_TOO_LARGE;
    end else if (match_next && guess_next == KIND_PNG) begin
      if (cnt_next >= COUNT_BITS'(PNG_MIN_BYTES) && wacc_next != '0 && hacc_next != '0 &&
          wacc_next[31:16] == '0 && hacc_next[31:16] == '0) begin
        res_next.status       = STATUS_OK;
        res_next.format_kind  = KIND_PNG;
        res_next.image_width  = wacc_next[15:0];
        res_next.image_height = hacc_next[15:0];
      end
    end else if (match_next && guess_next == KIND_GIF) begin
      if (cnt_next >= COUNT_BITS'(GIF_MIN_BYTES) && wacc_next != '0 && hacc_next != '0) begin
        res_next.status       = STATUS_OK;
        res_next.format_kind  = KIND_GIF;
        res_next.image_width  = wacc_next[15:0];
        res_next.image_height = hacc_next[15:0];
      end
    end else if (match_next && guess_next == KIND_JPEG) begin
      if (jstat.found) begin
        res_next.status       = STATUS_OK;
        res_next.format_kind  = KIND_JPEG;
        res_next.image_width  = jstat.width;
        res_next.image_height = jstat.height;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || finish) begin
      pos       <= '0;
      guess     <= KIND_NONE;
      match     <= 1'b1;
      wacc      <= '0;
      hacc      <= '0;
      cnt       <= '0;
      too_large <= 1'b0;
    end else if (proc) begin
      pos       <= pos_next;
      guess     <= guess_next;
      match     <= match_next;
      wacc      <= wacc_next;
      hacc      <= hacc_next;
      cnt       <= cnt_next;
      too_large <= too_large_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_item <= res_next;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench for image_format_size_sniffer_core: directed and random PNG, GIF and JPEG
// uploads, with a byte-level predictor, a result scoreboard and random idling on both sides.
// Depends on ifss_pkg and the core RTL.
module tb_top
  import ifss_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_BYTES = 300;
  localparam int RANDOM_FILES = 10;
  localparam int FILES_PER_ROUND = 4;
  localparam logic [23:0] COUNT_SAT = 24'hFFFFFF;
  localparam logic [63:0] PNG_MAGIC = 64'h89504E470D0A1A0A;
  localparam logic [47:0] GIF_MAGIC = 48'h474946383761;

  typedef logic [7:0] byte_q_t[$];
  typedef enum logic [2:0] {JP_SEEK, JP_MARKER, JP_LEN_HI, JP_LEN_LO, JP_SOF, JP_SKIP} jpeg_phase_t;
  typedef enum logic [1:0] {WALK_OPEN, WALK_FOUND, WALK_FAILED} walk_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [MAX_BYTES_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;

  image_format_size_sniffer_core u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // sniffer shadow state
  logic [23:0] limit_bytes = MAX_BYTES_RESET;
  logic [5:0] hdr_pos;
  logic [1:0] guess;
  logic hdr_ok;
  jpeg_phase_t jphase;
  logic [15:0] skip_left;
  logic [7:0] seg_marker;
  logic [15:0] seg_len;
  logic [31:0] wacc;
  logic [31:0] hacc;
  walk_t walk;
  logic [23:0] nbytes;
  logic oversize;

  out_item_t expected_results[$];
  byte_q_t file_buf;
  out_item_t want;

  int cycles = 0;
  int mismatches = 0;
  int bytes_sent = 0;
  int files_sent = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int hold_left = 0;
  bit send_steady = 1'b0;
  bit recv_steady = 1'b0;

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic log_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH cycle %0d: %s", cycles, msg);
  endtask

  function automatic logic frame_marker(input logic [7:0] m);
    return m >= 8'hC0 && m <= 8'hCF && m != 8'hC4 && m != 8'hC8 && m != 8'hCC;
  endfunction

  function automatic void clear_file_state();
    hdr_pos = '0;
    guess = KIND_NONE;
    hdr_ok = 1'b1;
    jphase = JP_SEEK;
    skip_left = '0;
    seg_marker = '0;
    seg_len = '0;
    wacc = '0;
    hacc = '0;
    walk = WALK_OPEN;
    nbytes = '0;
    oversize = 1'b0;
  endfunction

  function automatic void walk_jpeg(input logic [7:0] b);
    logic [15:0] r;
    if (walk != WALK_OPEN) return;
    case (jphase)
      JP_MARKER: begin
        if (b == JPEG_EOI || b == JPEG_SOS) begin
          walk = WALK_FAILED;
        end else if (b != JPEG_LEAD) begin
          seg_marker = b;
          jphase = JP_LEN_HI;
        end
      end
      JP_LEN_HI: begin
        seg_len = {b, 8'h00};
        jphase = JP_LEN_LO;
      end
      JP_LEN_LO: begin
        seg_len = seg_len | {8'h00, b};
        if (seg_len < 16'd2) begin
          walk = WALK_FAILED;
        end else if (frame_marker(seg_marker) && seg_len >= 16'd7) begin
          skip_left = 16'd5;
          wacc = '0;
          hacc = '0;
          jphase = JP_SOF;
        end else begin
          skip_left = seg_len - 16'd2;
          jphase = (skip_left != 0) ? JP_SKIP : JP_SEEK;
        end
      end
      JP_SOF: begin
        if (skip_left == 0) begin
          walk = WALK_FAILED;
        end else begin
          skip_left--;
          r = skip_left;
          if (r == 16'd3 || r == 16'd2) hacc = {16'h0, hacc[7:0], b};
          else if (r <= 16'd1) wacc = {16'h0, wacc[7:0], b};
          if (r == 0) walk = (wacc != 0 && hacc != 0) ? WALK_FOUND : WALK_FAILED;
        end
      end
      JP_SKIP: begin
        if (skip_left != 0) skip_left--;
        if (skip_left == 0) jphase = JP_SEEK;
      end
      default: jphase = (b == JPEG_LEAD) ? JP_MARKER : JP_SEEK;
    endcase
  endfunction

  function automatic void parse_header(input logic [7:0] b);
    int p;
    p = int'(hdr_pos);
    if (p == 0) begin
      guess = (b == PNG_LEAD) ? KIND_PNG : (b == GIF_LEAD) ? KIND_GIF :
              (b == JPEG_LEAD) ? KIND_JPEG : KIND_NONE;
      hdr_ok = guess != KIND_NONE;
      wacc = '0;
      hacc = '0;
    end else if (hdr_ok) begin
      case (guess)
        KIND_PNG: begin
          if (p < 8) hdr_ok = (b == PNG_MAGIC[63 - 8*p -: 8]);
          else if (p >= 16 && p < 20) wacc = {wacc[23:0], b};
          else if (p >= 20 && p < 24) hacc = {hacc[23:0], b};
        end
        KIND_GIF: begin
          if (p == 4) hdr_ok = (b == GIF_VER_7 || b == GIF_VER_9);
          else if (p < 6) hdr_ok = (b == GIF_MAGIC[47 - 8*p -: 8]);
          else if (p == 6) wacc = wacc | {24'h0, b};
          else if (p == 7) wacc = wacc | {16'h0, b, 8'h00};
          else if (p == 8) hacc = hacc | {24'h0, b};
          else if (p == 9) hacc = hacc | {16'h0, b, 8'h00};
        end
        KIND_JPEG: begin
          if (p == 1) hdr_ok = (b == JPEG_SOI);
          else walk_jpeg(b);
        end
        default: ;
      endcase
    end
  endfunction

  task automatic predict_sniff(input in_item_t req);
    out_item_t res;
    if (nbytes != COUNT_SAT) nbytes++;
    if (nbytes > limit_bytes) oversize = 1'b1;
    parse_header(req.data_byte);
    if (hdr_pos != 6'd63) hdr_pos++;
    if (req.last_byte) begin
      res = '0;
      res.status = STATUS_BAD;
      res.format_kind = KIND_NONE;
      if (oversize) begin
        res.status = STATUS_TOO_LARGE;
      end else if (hdr_ok && guess == KIND_PNG) begin
        if (nbytes >= PNG_MIN_BYTES && wacc != 0 && hacc != 0 &&
            wacc <= 32'hFFFF && hacc <= 32'hFFFF) begin
          res.status = STATUS_OK;
          res.format_kind = KIND_PNG;
          res.image_width = wacc[15:0];
          res.image_height = hacc[15:0];
        end
      end else if (hdr_ok && guess == KIND_GIF) begin
        if (nbytes >= GIF_MIN_BYTES && wacc != 0 && hacc != 0) begin
          res.status = STATUS_OK;
          res.format_kind = KIND_GIF;
          res.image_width = wacc[15:0];
          res.image_height = hacc[15:0];
        end
      end else if (hdr_ok && guess == KIND_JPEG && walk == WALK_FOUND) begin
        res.status = STATUS_OK;
        res.format_kind = KIND_JPEG;
        res.image_width = wacc[15:0];
        res.image_height = hacc[15:0];
      end
      res.file_bytes = nbytes;
      expected_results.push_back(res);
      clear_file_state();
    end
  endtask

  // result side: check each result as it is taken, then draw a stall for the next one
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_results.size() == 0) begin
        log_mismatch("result with no request outstanding");
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_item.status !== want.status)
          log_mismatch($sformatf("status %0d, expected %0d", out_item.status, want.status));
        if (out_item.format_kind !== want.format_kind)
          log_mismatch($sformatf("format_kind %0d, expected %0d",
                                 out_item.format_kind, want.format_kind));
        if (out_item.image_width !== want.image_width)
          log_mismatch($sformatf("image_width %0d, expected %0d",
                                 out_item.image_width, want.image_width));
        if (out_item.image_height !== want.image_height)
          log_mismatch($sformatf("image_height %0d, expected %0d",
                                 out_item.image_height, want.image_height));
        if (out_item.file_bytes !== want.file_bytes)
          log_mismatch($sformatf("file_bytes %0d, expected %0d",
                                 out_item.file_bytes, want.file_bytes));
      end
      hold_left = recv_steady ? 0 : $urandom_range(0, 17);
    end else if (out_valid === 1'b1 && hold_left != 0) begin
      hold_left--;
    end
  end

  always @(negedge clk) out_stall <= (hold_left != 0);

  task automatic send_byte(input logic [7:0] b, input logic last);
    in_item_t req;
    int gap;
    req.data_byte = b;
    req.last_byte = last;
    gap = send_steady ? 0 : $urandom_range(0, 17);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    bytes_sent++;
    predict_sniff(req);
  endtask

  task automatic send_file();
    for (int i = 0; i < file_buf.size(); i++) send_byte(file_buf[i], i == file_buf.size() - 1);
    files_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_bytes(input logic [23:0] v);
    @(negedge clk);
    cfg_data <= v;
    cfg_write <= 1'b1;
    @(negedge clk);
    cfg_write <= 1'b0;
    limit_bytes = v;
    cfg_writes++;
  endtask

  task automatic put(input logic [7:0] b);
    file_buf.push_back(b);
  endtask

  task automatic put_rand(input int n);
    repeat (n) put(8'($urandom_range(0, 255)));
  endtask

  task automatic put_hex(input string s);
    for (int i = 0; i + 1 < s.len(); i += 2) put(8'(s.substr(i, i + 1).atohex()));
  endtask

  task automatic trim_to(input int len);
    while (file_buf.size() > len) void'(file_buf.pop_back());
    while (file_buf.size() < len) put(8'($urandom_range(0, 255)));
  endtask

  task automatic make_png(input logic [31:0] w, input logic [31:0] h, input int len);
    file_buf = {};
    for (int i = 0; i < 8; i++) put(PNG_MAGIC[63 - 8*i -: 8]);
    put_hex("0000000D49484452");
    for (int i = 3; i >= 0; i--) put(w[8*i +: 8]);
    for (int i = 3; i >= 0; i--) put(h[8*i +: 8]);
    trim_to(len);
  endtask

  task automatic make_gif(input logic [7:0] ver, input logic [15:0] w, input logic [15:0] h,
                          input int len);
    file_buf = {};
    put_hex("47494638");
    put(ver);
    put(8'h61);
    put(w[7:0]);
    put(w[15:8]);
    put(h[7:0]);
    put(h[15:8]);
    trim_to(len);
  endtask

  function automatic logic [15:0] pick_dim();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0001;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic make_jpeg_random();
    logic [7:0] m;
    logic [15:0] len;
    logic [15:0] w;
    logic [15:0] h;
    file_buf = {};
    put(JPEG_LEAD);
    put(JPEG_SOI);
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 3) == 0) put(8'($urandom_range(0, 254)));
      repeat ($urandom_range(0, 2)) put(JPEG_LEAD);
      put(JPEG_LEAD);
      m = 8'($urandom_range(0, 254));
      put(m);
      case ($urandom_range(0, 19))
        0: len = 16'($urandom_range(0, 1));
        1: len = 16'($urandom_range(256, 300));
        default: len = 16'($urandom_range(2, 12));
      endcase
      put(len[15:8]);
      put(len[7:0]);
      if (len >= 2) put_rand(int'(len) - 2);
    end
    put(JPEG_LEAD);
    do m = 8'hC0 + 8'($urandom_range(0, 15)); while (!frame_marker(m));
    put(m);
    len = ($urandom_range(0, 5) == 0) ? 16'd6 : 16'($urandom_range(7, 12));
    put(len[15:8]);
    put(len[7:0]);
    h = pick_dim();
    w = pick_dim();
    put(8'($urandom_range(0, 255)));
    put(h[15:8]);
    put(h[7:0]);
    put(w[15:8]);
    put(w[7:0]);
    if (len > 7) put_rand(int'(len) - 7);
    put_rand($urandom_range(0, 3));
  endtask

  task automatic make_random_file();
    logic [31:0] w;
    logic [31:0] h;
    logic [7:0] ver;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        w = ($urandom_range(0, 7) == 0) ? $urandom : {16'h0, pick_dim()};
        h = ($urandom_range(0, 7) == 0) ? $urandom : {16'h0, pick_dim()};
        make_png(w, h, 24 + $urandom_range(0, 6));
      end
      3, 4: begin
        ver = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) :
              ($urandom_range(0, 1) ? GIF_VER_9 : GIF_VER_7);
        make_gif(ver, pick_dim(), pick_dim(), 10 + $urandom_range(0, 6));
      end
      5, 6, 7: make_jpeg_random();
      default: begin
        file_buf = {};
        case ($urandom_range(0, 3))
          0: put(PNG_LEAD);
          1: put(GIF_LEAD);
          2: put(JPEG_LEAD);
          default: put(8'($urandom_range(0, 255)));
        endcase
        put_rand($urandom_range(0, 11));
      end
    endcase
    if ($urandom_range(0, 5) == 0)
      file_buf[$urandom_range(0, (file_buf.size() > 30 ? 30 : file_buf.size()) - 1)] =
        8'($urandom_range(0, 255));
    if ($urandom_range(0, 7) == 0) trim_to($urandom_range(1, file_buf.size()));
  endtask

  task automatic test_png_headers();
    make_png(32'h0000FFFF, 32'h00000001, 24);
    send_file();
    make_png(32'h00010000, 32'h00000005, 26);
    send_file();
    make_png(32'h00000007, 32'h00000000, 24);
    send_file();
    make_png(32'h00000003, 32'h00000004, 23);
    send_file();
    make_png(32'h00000001, 32'h00000001, 24);
    file_buf[6] = 8'h1B;
    send_file();
  endtask

  task automatic test_gif_headers();
    make_gif(GIF_VER_7, 16'h0001, 16'hFFFF, 10);
    send_file();
    make_gif(GIF_VER_9, 16'hFFFF, 16'h1234, 14);
    send_file();
    make_gif(8'h38, 16'h0005, 16'h0005, 10);
    send_file();
    make_gif(GIF_VER_9, 16'h0005, 16'h0000, 10);
    send_file();
    make_gif(GIF_VER_7, 16'h0005, 16'h0005, 9);
    send_file();
  endtask

  task automatic test_jpeg_markers();
    // junk, fill, an APP segment, an empty DHT, a short SOF skipped, then a real frame
    file_buf = {};
    put_hex("FFD80012FFFFFFE00004AABBFFC40002FFC00006010203");
    put_hex("04FFC200110801E00280000000000000000000FFD9");
    send_file();
    file_buf = {};
    put_hex("FFD8FFD9");
    send_file();
    file_buf = {};
    put_hex("FFD8FFE10002FFDA00");
    send_file();
    file_buf = {};
    put_hex("FFD8FFE00001");
    send_file();
    file_buf = {};
    put_hex("FFD8FFC100080800");
    send_file();
    file_buf = {};
    put_hex("FFD8FFDB00");
    send_file();
    file_buf = {};
    put_hex("FFD8FFCF000708001000000000");
    send_file();
    file_buf = {};
    put_hex("FFD8FFC9000708FFFFFFFF");
    send_file();
    file_buf = {};
    put_hex("FFD9FFC0000708000100010000");
    send_file();
  endtask

  task automatic test_unknown_leads();
    file_buf = {};
    put(8'h00);
    send_file();
    file_buf = {};
    put(GIF_LEAD);
    send_file();
    file_buf = {};
    put_hex("12FFD8");
    send_file();
  endtask

  task automatic test_size_limit();
    drain_results();
    write_max_bytes(24'd0);
    file_buf = {};
    put(PNG_LEAD);
    send_file();
    drain_results();
    write_max_bytes(24'd1);
    file_buf = {};
    put(8'h89);
    send_file();
    file_buf = {};
    put_hex("8950");
    send_file();
    drain_results();
    write_max_bytes(24'd24);
    make_png(32'h00000280, 32'h000001E0, 24);
    send_file();
    make_png(32'h00000280, 32'h000001E0, 25);
    send_file();
    drain_results();
    write_max_bytes(24'hFFFFFF);
    make_gif(GIF_VER_9, 16'h0140, 16'h00F0, 12);
    send_file();
  endtask

  task automatic test_random_files();
    int first_bytes;
    int first_files;
    first_bytes = bytes_sent;
    first_files = files_sent;
    while (bytes_sent - first_bytes < RANDOM_BYTES || files_sent - first_files < RANDOM_FILES) begin
      if ((files_sent - first_files) % FILES_PER_ROUND == 0) begin
        drain_results();
        case ($urandom_range(0, 3))
          0: write_max_bytes(24'hFFFFFF);
          1: write_max_bytes(MAX_BYTES_RESET);
          2: write_max_bytes(24'($urandom_range(8, 40)));
          default: write_max_bytes(24'($urandom_range(0, 24'hFFFFFF)));
        endcase
      end
      send_steady = $urandom_range(0, 4) == 0;
      recv_steady = $urandom_range(0, 4) == 0;
      make_random_file();
      send_file();
    end
  endtask

  initial begin
    clear_file_state();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_png_headers();
    test_gif_headers();
    test_jpeg_markers();
    test_unknown_leads();
    test_size_limit();
    test_random_files();
    drain_results();
    $display("Sent %0d files (%0d bytes) over %0d max_bytes settings", files_sent, bytes_sent,
             cfg_writes);
    $display("Checked %0d results, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
